[rtl/tcp_pkg.sv]
package tcp_pkg;

  localparam int OFFSET_BITS = 16;
  localparam logic [16:0] OFF_MAX = 17'((1 << OFFSET_BITS) - 1);

  localparam logic [4:0] PH_IDLE          = 5'd0;
  localparam logic [4:0] PH_DONE          = 5'd1;
  localparam logic [4:0] PH_HDR           = 5'd2;
  localparam logic [4:0] PH_SID_LEN       = 5'd3;
  localparam logic [4:0] PH_CS_HI         = 5'd4;
  localparam logic [4:0] PH_CS_LO         = 5'd5;
  localparam logic [4:0] PH_COMP_LEN      = 5'd6;
  localparam logic [4:0] PH_EXTS_HI       = 5'd7;
  localparam logic [4:0] PH_EXTS_LO       = 5'd8;
  localparam logic [4:0] PH_EXT_T_HI      = 5'd9;
  localparam logic [4:0] PH_EXT_T_LO      = 5'd10;
  localparam logic [4:0] PH_EXT_L_HI      = 5'd11;
  localparam logic [4:0] PH_EXT_L_LO      = 5'd12;
  localparam logic [4:0] PH_SNI_HI        = 5'd13;
  localparam logic [4:0] PH_SNI_LO        = 5'd14;
  localparam logic [4:0] PH_NAME_TYPE     = 5'd15;
  localparam logic [4:0] PH_NLEN_HI_HOST  = 5'd16;
  localparam logic [4:0] PH_NLEN_HI_OTHER = 5'd17;
  localparam logic [4:0] PH_NLEN_LO_HOST  = 5'd18;
  localparam logic [4:0] PH_NLEN_LO_OTHER = 5'd19;
  localparam logic [4:0] PH_NAME_FIRST    = 5'd20;
  localparam logic [4:0] PH_NAME_REST     = 5'd21;
  localparam logic [4:0] PH_ALPN_HI       = 5'd22;
  localparam logic [4:0] PH_ALPN_LO       = 5'd23;
  localparam logic [4:0] PH_PROTO_LEN     = 5'd24;
  localparam logic [4:0] PH_PROTO_FIRST   = 5'd25;
  localparam logic [4:0] PH_PROTO_REST    = 5'd26;

  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_HOST       = 3'd1;
  localparam logic [2:0] KIND_ALPN       = 3'd2;
  localparam logic [2:0] KIND_ALPN_EMPTY = 3'd3;
  localparam logic [2:0] KIND_ALPN_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       entry_start;
    logic       entry_end;
    logic       hostname_valid;
    logic       malformed;
  } tcp_res_t;

  function automatic logic [7:0] lower_latin1(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    if (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7) return c + 8'h20;
    return c;
  endfunction

  function automatic logic host_char_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'h2D || c == 8'h2E || c == 8'hAA || c == 8'hB2 ||
           c == 8'hB3 || c == 8'hB5 || c == 8'hB9 || c == 8'hBA ||
           (c >= 8'hBC && c <= 8'hBE) || (c >= 8'hDF && c != 8'hF7);
  endfunction

endpackage

[rtl/tls_client_hello_sni_alpn_parser.sv]
// Byte-stream ClientHello parser: one payload byte is taken per cycle and one
// result leaves per byte, in order, after passing the input register and then
// the result register. The parse state advances with simple
// 18- and 25-bit add-and-compare bounds on each byte, so a new byte may follow in
// every cycle; the only stall is a full result register whose result is not
// taken. A byte flagged first_byte restarts the parse at payload offset zero.
module tls_client_hello_sni_alpn_parser import tcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_payload_length,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_entry_start,
  output logic        out_entry_end,
  output logic        out_hostname_valid,
  output logic        out_malformed
);

  // input stage
  logic        iv_r;
  logic [7:0]  b_r;
  logic [15:0] plen_r;
  logic        first_r;
  // result stage
  logic        ov_r;
  tcp_res_t    res_r, res;

  logic adv;      // input register moves into result register
  assign adv = iv_r && (!ov_r || out_ready);
  assign in_ready = !iv_r || adv;

  // parse state
  logic [4:0]  ph_r, ph_nxt;
  logic [15:0] off_r, off_nxt;
  logic [24:0] hs_end_r, hs_end_nxt;
  logic [15:0] exts_end_r, exts_end_nxt, ext_end_r, ext_end_nxt, ext_kind_r, ext_kind_nxt;
  logic [15:0] list_end_r, list_end_nxt, skip_r, skip_nxt, nlen_r, nlen_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        dot_r, dot_nxt, cok_r, cok_nxt;

  always_comb begin
    logic [4:0]  ph;
    logic [15:0] pos, len, nl;
    logic [17:0] p1, tgt;
    logic [7:0]  ob;
    logic        mal, do_jump, do_ext;
    logic [4:0]  jph;
    logic [17:0] ext_pos;
    ph_nxt = ph_r; off_nxt = off_r; hs_end_nxt = hs_end_r; exts_end_nxt = exts_end_r;
    ext_end_nxt = ext_end_r; ext_kind_nxt = ext_kind_r; list_end_nxt = list_end_r;
    skip_nxt = skip_r; nlen_nxt = nlen_r; hi_nxt = hi_r; dot_nxt = dot_r; cok_nxt = cok_r;
    res = '0;
    ph = ph_r; pos = off_r; len = {hi_r, b_r}; mal = 1'b0;
    do_jump = 1'b0; do_ext = 1'b0; jph = PH_DONE; tgt = '0; ext_pos = '0;
    ob = lower_latin1(b_r); nl = nlen_r - 16'd1;
    if (first_r) begin
      hs_end_nxt = '0; exts_end_nxt = '0; ext_end_nxt = '0; ext_kind_nxt = '0;
      list_end_nxt = '0; skip_nxt = '0; nlen_nxt = '0; hi_nxt = '0;
      dot_nxt = 1'b0; cok_nxt = 1'b1;
      ph = PH_HDR; pos = '0;
    end else begin
      pos = off_r + 16'd1;
      pos = pos & 16'(OFF_MAX);
    end
    p1 = {2'b0, pos} + 18'd1;
    if (first_r || (ph_r != PH_IDLE && ph_r != PH_DONE)) begin
      off_nxt = pos;
      ph_nxt = ph;
      if (!first_r && skip_r != 16'd0) begin
        skip_nxt = skip_r - 16'd1;
      end else begin
        case (ph)
          PH_HDR: begin
            if (pos == 16'd0) begin
              if (plen_r < 16'd43 || {1'b0, plen_r} > OFF_MAX || b_r != 8'h16) mal = 1'b1;
            end else if (pos == 16'd3) hi_nxt = b_r;
            else if (pos == 16'd4) begin
              if ({1'b0, len} + 17'd5 > {1'b0, plen_r}) mal = 1'b1;
            end else if (pos == 16'd5) begin
              if (b_r != 8'h01) mal = 1'b1;
            end else if (pos == 16'd6) hs_end_nxt = {17'd0, b_r};
            else if (pos == 16'd7) hs_end_nxt = {9'd0, hs_end_r[7:0], b_r};
            else if (pos == 16'd8) begin
              hs_end_nxt = 25'd9 + {1'b0, hs_end_r[15:0], b_r};
              if (hs_end_nxt > {9'd0, plen_r} || hs_end_nxt < 25'd44) mal = 1'b1;
              else begin do_jump = 1'b1; tgt = 18'd43; jph = PH_SID_LEN; end
            end
          end
          PH_SID_LEN: begin
            if ({7'd0, p1} + 25'(b_r) + 25'd2 > hs_end_r) mal = 1'b1;
            else begin do_jump = 1'b1; tgt = p1 + 18'(b_r); jph = PH_CS_HI; end
          end
          PH_CS_HI: begin hi_nxt = b_r; ph_nxt = PH_CS_LO; end
          PH_CS_LO: begin
            if ({7'd0, p1} + 25'(len) + 25'd1 > hs_end_r) mal = 1'b1;
            else begin do_jump = 1'b1; tgt = p1 + 18'(len); jph = PH_COMP_LEN; end
          end
          PH_COMP_LEN: begin
            if ({7'd0, p1} + 25'(b_r) + 25'd2 > hs_end_r) mal = 1'b1;
            else begin do_jump = 1'b1; tgt = p1 + 18'(b_r); jph = PH_EXTS_HI; end
          end
          PH_EXTS_HI: begin hi_nxt = b_r; ph_nxt = PH_EXTS_LO; end
          PH_EXTS_LO: begin
            if ({7'd0, p1} + 25'(len) > hs_end_r) mal = 1'b1;
            else begin
              exts_end_nxt = 16'(p1 + 18'(len));
              do_ext = 1'b1; ext_pos = p1;
            end
          end
          PH_EXT_T_HI, PH_EXT_L_HI, PH_SNI_HI, PH_ALPN_HI: begin
            hi_nxt = b_r; ph_nxt = ph + 5'd1;
          end
          PH_NLEN_HI_HOST, PH_NLEN_HI_OTHER: begin
            hi_nxt = b_r; ph_nxt = ph + 5'd2;
          end
          PH_EXT_T_LO: begin ext_kind_nxt = len; ph_nxt = PH_EXT_L_HI; end
          PH_EXT_L_LO: begin
            if (p1 + 18'(len) > {2'b0, exts_end_r}) mal = 1'b1;
            else begin
              ext_end_nxt = 16'(p1 + 18'(len));
              if (ext_kind_r == 16'd0 && len >= 16'd5) ph_nxt = PH_SNI_HI;
              else if (ext_kind_r == 16'd16 && len >= 16'd3) ph_nxt = PH_ALPN_HI;
              else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_nxt}; end
            end
          end
          PH_SNI_LO: begin
            if (p1 + 18'(len) > {2'b0, ext_end_r}) mal = 1'b1;
            else begin
              list_end_nxt = 16'(p1 + 18'(len));
              if (p1 + 18'd3 <= {2'b0, list_end_nxt}) begin
                do_jump = 1'b1; tgt = p1; jph = PH_NAME_TYPE;
              end else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_r}; end
            end
          end
          PH_NAME_TYPE: ph_nxt = (b_r == 8'd0) ? PH_NLEN_HI_HOST : PH_NLEN_HI_OTHER;
          PH_NLEN_LO_HOST, PH_NLEN_LO_OTHER: begin
            if (p1 + 18'(len) > {2'b0, list_end_r}) mal = 1'b1;
            else if (ph == PH_NLEN_LO_HOST && len != 16'd0) begin
              nlen_nxt = len; dot_nxt = 1'b0;
              cok_nxt = (len >= 16'd3 && len <= 16'd253);
              ph_nxt = PH_NAME_FIRST;
            end else if (p1 + 18'(len) + 18'd3 <= {2'b0, list_end_r}) begin
              do_jump = 1'b1; tgt = p1 + 18'(len); jph = PH_NAME_TYPE;
            end else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_r}; end
          end
          PH_NAME_FIRST, PH_NAME_REST: begin
            res.kind = KIND_HOST; res.out_byte = ob;
            res.entry_start = (ph == PH_NAME_FIRST);
            if (ob == 8'h2E) dot_nxt = 1'b1;
            if (!host_char_ok(ob)) cok_nxt = 1'b0;
            nlen_nxt = nl;
            if (nl == 16'd0) begin
              res.entry_end = 1'b1;
              res.hostname_valid = cok_nxt & dot_nxt;
              if (p1 + 18'd3 <= {2'b0, list_end_r}) begin
                do_jump = 1'b1; tgt = p1; jph = PH_NAME_TYPE;
              end else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_r}; end
            end else ph_nxt = PH_NAME_REST;
          end
          PH_ALPN_LO: begin
            if (p1 + 18'(len) > {2'b0, ext_end_r}) begin
              do_ext = 1'b1; ext_pos = {2'b0, ext_end_r};
            end else begin
              list_end_nxt = 16'(p1 + 18'(len));
              res.kind = KIND_ALPN_CLEAR;
              if (p1 + 18'd1 <= {2'b0, list_end_nxt}) begin
                do_jump = 1'b1; tgt = p1; jph = PH_PROTO_LEN;
              end else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_r}; end
            end
          end
          PH_PROTO_LEN: begin
            if (p1 + 18'(b_r) > {2'b0, list_end_r}) begin
              do_ext = 1'b1; ext_pos = {2'b0, ext_end_r};
            end else if (b_r == 8'd0) begin
              res.kind = KIND_ALPN_EMPTY; res.entry_start = 1'b1; res.entry_end = 1'b1;
              if (p1 + 18'd1 <= {2'b0, list_end_r}) begin
                do_jump = 1'b1; tgt = p1; jph = PH_PROTO_LEN;
              end else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_r}; end
            end else begin
              nlen_nxt = {8'd0, b_r}; ph_nxt = PH_PROTO_FIRST;
            end
          end
          PH_PROTO_FIRST, PH_PROTO_REST: begin
            res.kind = KIND_ALPN; res.out_byte = b_r;
            res.entry_start = (ph == PH_PROTO_FIRST);
            nlen_nxt = nl;
            if (nl == 16'd0) begin
              res.entry_end = 1'b1;
              if (p1 + 18'd1 <= {2'b0, list_end_r}) begin
                do_jump = 1'b1; tgt = p1; jph = PH_PROTO_LEN;
              end else begin do_ext = 1'b1; ext_pos = {2'b0, ext_end_r}; end
            end else ph_nxt = PH_PROTO_REST;
          end
          default: ph_nxt = PH_DONE;
        endcase
        // extension walk: next header must fit inside the extensions block
        if (do_ext) begin
          if (ext_pos + 18'd4 > {2'b0, exts_end_nxt}) ph_nxt = PH_DONE;
          else begin do_jump = 1'b1; tgt = ext_pos; jph = PH_EXT_T_HI; end
        end
        if (do_jump && !(do_ext && ext_pos + 18'd4 > {2'b0, exts_end_nxt})) begin
          ph_nxt = jph;
          skip_nxt = 16'(tgt - p1);
        end
        if (mal) ph_nxt = PH_DONE;
      end
    end
    res.malformed = mal;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0; ov_r <= 1'b0;
      ph_r <= PH_IDLE; off_r <= '0; hs_end_r <= '0; exts_end_r <= '0; ext_end_r <= '0;
      ext_kind_r <= '0; list_end_r <= '0; skip_r <= '0; nlen_r <= '0; hi_r <= '0;
      dot_r <= 1'b0; cok_r <= 1'b1;
    end else begin
      if (in_ready) iv_r <= in_valid;
      if (adv) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (adv) begin
        ph_r <= ph_nxt; off_r <= off_nxt; hs_end_r <= hs_end_nxt;
        exts_end_r <= exts_end_nxt; ext_end_r <= ext_end_nxt; ext_kind_r <= ext_kind_nxt;
        list_end_r <= list_end_nxt; skip_r <= skip_nxt; nlen_r <= nlen_nxt;
        hi_r <= hi_nxt; dot_r <= dot_nxt; cok_r <= cok_nxt;
      end
    end
  end

  // payload registers: hold until moved on
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      b_r <= in_data_byte; plen_r <= in_payload_length; first_r <= in_first_byte;
    end
    if (adv) res_r <= res;
  end

  assign out_valid          = ov_r;
  assign out_kind           = res_r.kind;
  assign out_out_byte       = res_r.out_byte;
  assign out_entry_start    = res_r.entry_start;
  assign out_entry_end      = res_r.entry_end;
  assign out_hostname_valid = res_r.hostname_valid;
  assign out_malformed      = res_r.malformed;

endmodule
